[rtl/core/pbga_pkg.sv]
// Shared types and constants for the piecewise Bezier gait angle block.
`default_nettype none

package pbga_pkg;

    // Default widths of the fraction and of one packed angle.
    localparam int FRACTION_BITS_DEF = 16;
    localparam int ANGLE_BITS_DEF    = 16;

    // Number of gait phases and the width of a phase number.
    localparam int PHASES  = 5;
    localparam int PHASE_W = 3;

    // Width of the configuration register index.
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PHASE0_POINTS = 3'd0,
        REG_PHASE1_POINTS = 3'd1,
        REG_PHASE2_POINTS = 3'd2,
        REG_PHASE3_POINTS = 3'd3,
        REG_PHASE4_POINTS = 3'd4
    } cfg_reg_t;

    // Reset values of the packed control point registers, one per phase.
    localparam logic [47:0] PHASE_RESET [PHASES] = '{
        48'd8246463037440,
        48'd2748904900480,
        48'd16492716360320,
        48'd32985684381440,
        48'd503324160
    };

endpackage : pbga_pkg

`default_nettype wire

[rtl/core/pbga_select.sv]
// Front cell: control point registers, phase selection and local parameter.
`default_nettype none

module pbga_select #(
    parameter int FRACTION_BITS = pbga_pkg::FRACTION_BITS_DEF,
    parameter int ANGLE_BITS    = pbga_pkg::ANGLE_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [pbga_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [3*ANGLE_BITS-1:0]          cfg_wr_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [FRACTION_BITS:0]           in_fraction,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [pbga_pkg::PHASE_W-1:0]     out_phase,
    output logic [FRACTION_BITS:0]           out_s,
    output logic [FRACTION_BITS:0]           out_u,
    output logic [4*ANGLE_BITS-1:0]          out_pts
);
    import pbga_pkg::*;

    localparam int F  = FRACTION_BITS;
    localparam int A  = ANGLE_BITS;
    localparam int CW = 3 * A;
    localparam int TW = F + 3;
    localparam logic [F:0] ONE = (F+1)'(1) << F;

    logic [CW-1:0]      points_reg [PHASES];
    logic [F:0]         t_sat;
    logic [TW-1:0]      five_t;
    logic [TW-1:0]      s_full;
    logic [PHASE_W-1:0] phase_next;
    logic [F:0]         s_next;
    logic [F:0]         u_next;
    logic [CW-1:0]      sel_points;
    logic [4*A-1:0]     pts_next;
    logic               valid_reg;
    logic               valid_next;
    logic [PHASE_W-1:0] phase_reg;
    logic [F:0]         s_reg;
    logic [F:0]         u_reg;
    logic [4*A-1:0]     pts_reg;

    // Configuration writes; indexes past the last phase are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PHASES; i++) begin
                points_reg[i] <= CW'(PHASE_RESET[i]);
            end
        end else if (cfg_wr_en &&
                     (cfg_wr_index inside {[REG_PHASE0_POINTS:REG_PHASE4_POINTS]})) begin
            points_reg[cfg_wr_index] <= cfg_wr_data;
        end
    end

    // Saturate the fraction, scale by five and find the phase. A boundary
    // value belongs to the earlier phase, so the compares are strict.
    always_comb begin
        t_sat      = (in_fraction > ONE) ? ONE : in_fraction;
        five_t     = (TW'(t_sat) << 2) + TW'(t_sat);
        phase_next = '0;
        for (int j = 1; j < PHASES; j++) begin
            if (five_t > (TW'(j) << F)) begin
                phase_next = phase_next + PHASE_W'(1);
            end
        end
        s_full     = five_t - (TW'(phase_next) << F);
        s_next     = s_full[F:0];
        u_next     = ONE - s_next;
        sel_points = points_reg[phase_next];
    end

    // The last control point is used twice.
    assign pts_next = {sel_points[3*A-1:2*A], sel_points[3*A-1:2*A],
                       sel_points[2*A-1:A],   sel_points[A-1:0]};

    // Stage handshake: take a request when empty or when draining.
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            phase_reg <= phase_next;
            s_reg     <= s_next;
            u_reg     <= u_next;
            pts_reg   <= pts_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_phase = phase_reg;
    assign out_s     = s_reg;
    assign out_u     = u_reg;
    assign out_pts   = pts_reg;

endmodule : pbga_select

`default_nettype wire

[rtl/core/pbga_cell.sv]
// One de Casteljau cell: blends neighboring points by u and s, one level a cell.
`default_nettype none

module pbga_cell #(
    parameter int FRACTION_BITS = pbga_pkg::FRACTION_BITS_DEF,
    parameter int POINTS        = 4,
    parameter int IN_BITS       = pbga_pkg::ANGLE_BITS_DEF
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  logic [pbga_pkg::PHASE_W-1:0]                in_phase,
    input  logic [FRACTION_BITS:0]                      in_s,
    input  logic [FRACTION_BITS:0]                      in_u,
    input  logic [POINTS*IN_BITS-1:0]                   in_pts,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output logic [pbga_pkg::PHASE_W-1:0]                out_phase,
    output logic [FRACTION_BITS:0]                      out_s,
    output logic [FRACTION_BITS:0]                      out_u,
    output logic [(POINTS-1)*(IN_BITS+FRACTION_BITS)-1:0] out_pts
);
    import pbga_pkg::*;

    localparam int F  = FRACTION_BITS;
    localparam int WI = IN_BITS;
    localparam int WO = IN_BITS + FRACTION_BITS;
    localparam int WP = IN_BITS + FRACTION_BITS + 2;
    localparam int NO = POINTS - 1;

    logic [NO*WO-1:0]   pts_next;
    logic [NO*WO-1:0]   pts_reg;
    logic               valid_reg;
    logic               valid_next;
    logic [PHASE_W-1:0] phase_reg;
    logic [F:0]         s_reg;
    logic [F:0]         u_reg;

    // Each lane forms u*P[i] + s*P[i+1]. With u + s equal to one the sum is
    // a convex combination and fits the output width exactly.
    for (genvar i = 0; i < NO; i++) begin : g_lane
        logic signed [WI-1:0] pa;
        logic signed [WI-1:0] pb;
        logic signed [WP-1:0] blend;

        assign pa    = $signed(in_pts[i*WI +: WI]);
        assign pb    = $signed(in_pts[(i+1)*WI +: WI]);
        assign blend = pa * $signed({1'b0, in_u}) + pb * $signed({1'b0, in_s});
        assign pts_next[i*WO +: WO] = blend[WO-1:0];
    end

    // Stage handshake.
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            phase_reg <= in_phase;
            s_reg     <= in_s;
            u_reg     <= in_u;
            pts_reg   <= pts_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_phase = phase_reg;
    assign out_s     = s_reg;
    assign out_u     = u_reg;
    assign out_pts   = pts_reg;

endmodule : pbga_cell

`default_nettype wire

[rtl/core/piecewise_bezier_gait_angle.sv]
// Top level of the piecewise cubic Bezier gait angle generator.
//
// Usage: each request on the s_ channel carries a gait cycle fraction
// (unsigned, 2^FRACTION_BITS means one full cycle; larger values clamp to
// the end of the cycle). Each request yields exactly one result on the m_
// channel: the knee angle in signed Q9.7 degrees, rounded half up, and the
// phase number 0 to 4. Results leave in request order.
// The datapath is a row of five registered cells: phase select, three
// de Casteljau blend levels and a rounding output register. One request is
// taken every cycle unless the row is full and the receiver stalls.
// Every cell holds its own valid bit, so while the receiver stalls the row
// keeps filling empty cells and s_ready drops only when all five are full.
// Control points must be written by the user through cfg_wr_en, cfg_wr_index,
// cfg_wr_data only while no request is in flight; the block does not
// enforce it. Indexes above four are ignored. A synchronous reset (aresetn
// low) empties the row and loads the default stance and swing control points.
`default_nettype none

module piecewise_bezier_gait_angle #(
    parameter int FRACTION_BITS = pbga_pkg::FRACTION_BITS_DEF,
    parameter int ANGLE_BITS    = pbga_pkg::ANGLE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [pbga_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [3*ANGLE_BITS-1:0]         cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [FRACTION_BITS:0]          s_cycle_fraction,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [ANGLE_BITS-1:0]    m_joint_angle,
    output logic [pbga_pkg::PHASE_W-1:0]    m_phase_index
);
    import pbga_pkg::*;

    localparam int F  = FRACTION_BITS;
    localparam int A  = ANGLE_BITS;
    localparam int W1 = A + F;
    localparam int W2 = A + 2 * F;
    localparam int VW = A + 3 * F;
    localparam logic [VW-1:0] HALF = VW'(1) << (3 * F - 1);

    logic               c0_valid, c0_ready;
    logic [PHASE_W-1:0] c0_phase;
    logic [F:0]         c0_s, c0_u;
    logic [4*A-1:0]     c0_pts;
    logic               c1_valid, c1_ready;
    logic [PHASE_W-1:0] c1_phase;
    logic [F:0]         c1_s, c1_u;
    logic [3*W1-1:0]    c1_pts;
    logic               c2_valid, c2_ready;
    logic [PHASE_W-1:0] c2_phase;
    logic [F:0]         c2_s, c2_u;
    logic [2*W2-1:0]    c2_pts;
    logic               c3_valid, c3_ready;
    logic [PHASE_W-1:0] c3_phase;
    logic [F:0]         c3_s, c3_u;
    logic [VW-1:0]      c3_pts;
    logic [VW-1:0]      rounded;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [A-1:0]       angle_reg;
    logic [PHASE_W-1:0] phase_reg;

    // Phase select and control point registers.
    pbga_select #(
        .FRACTION_BITS (FRACTION_BITS),
        .ANGLE_BITS    (ANGLE_BITS)
    ) u_select (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .in_fraction  (s_cycle_fraction),
        .out_valid    (c0_valid),
        .out_ready    (c0_ready),
        .out_phase    (c0_phase),
        .out_s        (c0_s),
        .out_u        (c0_u),
        .out_pts      (c0_pts)
    );

    // First blend level: four points to three.
    pbga_cell #(
        .FRACTION_BITS (FRACTION_BITS),
        .POINTS        (4),
        .IN_BITS       (A)
    ) u_cell1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (c0_valid),
        .in_ready  (c0_ready),
        .in_phase  (c0_phase),
        .in_s      (c0_s),
        .in_u      (c0_u),
        .in_pts    (c0_pts),
        .out_valid (c1_valid),
        .out_ready (c1_ready),
        .out_phase (c1_phase),
        .out_s     (c1_s),
        .out_u     (c1_u),
        .out_pts   (c1_pts)
    );

    // Second blend level: three points to two.
    pbga_cell #(
        .FRACTION_BITS (FRACTION_BITS),
        .POINTS        (3),
        .IN_BITS       (W1)
    ) u_cell2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (c1_valid),
        .in_ready  (c1_ready),
        .in_phase  (c1_phase),
        .in_s      (c1_s),
        .in_u      (c1_u),
        .in_pts    (c1_pts),
        .out_valid (c2_valid),
        .out_ready (c2_ready),
        .out_phase (c2_phase),
        .out_s     (c2_s),
        .out_u     (c2_u),
        .out_pts   (c2_pts)
    );

    // Third blend level: two points to the curve value, scaled by 2^(3F).
    pbga_cell #(
        .FRACTION_BITS (FRACTION_BITS),
        .POINTS        (2),
        .IN_BITS       (W2)
    ) u_cell3 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (c2_valid),
        .in_ready  (c2_ready),
        .in_phase  (c2_phase),
        .in_s      (c2_s),
        .in_u      (c2_u),
        .in_pts    (c2_pts),
        .out_valid (c3_valid),
        .out_ready (c3_ready),
        .out_phase (c3_phase),
        .out_s     (c3_s),
        .out_u     (c3_u),
        .out_pts   (c3_pts)
    );

    // Round half up: add one half, then keep the bits above the scale.
    // The scale factors s and u are no longer needed past this point.
    assign rounded = c3_pts + HALF;

    // Output register.
    assign c3_ready       = !out_valid_reg || m_ready;
    assign out_valid_next = c3_ready ? c3_valid : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (c3_ready && c3_valid) begin
            angle_reg <= rounded[3*F +: A];
            phase_reg <= c3_phase;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_joint_angle = $signed(angle_reg);
    assign m_phase_index = phase_reg;

endmodule : piecewise_bezier_gait_angle

`default_nettype wire

[rtl/core/pbga_checker.sv]
// Port-level checks for the gait angle generator and their binding.
`default_nettype none

module pbga_checker #(
    parameter int ANGLE_BITS = pbga_pkg::ANGLE_BITS_DEF
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [ANGLE_BITS-1:0]  m_joint_angle,
    input logic [pbga_pkg::PHASE_W-1:0]  m_phase_index
);
    import pbga_pkg::*;

    // Reset empties the row, so no result shows right after it.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A stalled result holds its value.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_joint_angle)
                                && $stable(m_phase_index))
        else $error("stalled result changed");

    // Only five phases exist.
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_phase_index <= PHASE_W'(PHASES - 1))
        else $error("phase index out of range");

    // When the output side can move, every cell can move and a request can be taken.
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("request refused while the output side was free");

endmodule : pbga_checker

bind piecewise_bezier_gait_angle pbga_checker #(
    .ANGLE_BITS (ANGLE_BITS)
) u_pbga_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_joint_angle (m_joint_angle),
    .m_phase_index (m_phase_index)
);

`default_nettype wire
